/* design/slr_pkg.sv */
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants for the stereo linear resampler.
// Holds the fixed-point format, the controller states and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int FRAC_BITS   = 10;
  localparam int SAMPLE_W    = 16;
  localparam int PITCH_W     = 15;
  localparam int PHASE_W     = 15;
  // Holds a phase below one step plus the largest pitch.
  localparam int ACC_W       = ((FRAC_BITS > PITCH_W) ? FRAC_BITS : PITCH_W) + 1;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 6;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
  localparam int QUOT_W      = PROD_W - FRAC_BITS;
  localparam int SUM_W       = QUOT_W + 1;

  localparam logic [ACC_W-1:0]   ONE_STEP    = ACC_W'(1) << FRAC_BITS;
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);
  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(MAX_RESULTS - 1);
  localparam logic [PROD_W-1:0]  ROUND_BIAS  = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN
  } ctl_state_t;

  typedef struct packed {
    logic load;   // take the input item
    logic skip;   // item makes no output, commit at once
    logic mul;    // register the two products
    logic emit;   // load the output register and advance the phase
  } slr_cmd_t;

  typedef struct packed {
    logic phase_whole;  // stored phase is at or above one step
    logic out_busy;     // output register holds an item that is not taken
    logic last;         // the pending output is the last for this item
  } slr_sts_t;

endpackage

/* design/slr_ctrl.sv */
// ----------------------------------------------------------------------------
// slr_ctrl: controller for the stereo linear resampler.
// Commits an item that makes no output at once, and steps any other through
// multiply and finish phases, one output item per pass, until the last one.
// ----------------------------------------------------------------------------
module slr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  slr_pkg::slr_sts_t sts,
  output slr_pkg::slr_cmd_t cmd
);

  slr_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.phase_whole) begin
            cmd.skip = 1'b1;
          end else begin
            state_nxt = slr_pkg::ST_MUL;
          end
        end
      end
      slr_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = slr_pkg::ST_FIN;
      end
      slr_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? slr_pkg::ST_IDLE : slr_pkg::ST_MUL;
        end
      end
      default: begin
        state_nxt = slr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/slr_datapath.sv */
// ----------------------------------------------------------------------------
// slr_datapath: sample, phase and output registers of the resampler.
// Forms (cur - prev) * phase per channel, divides by one step with rounding
// toward zero, adds prev and saturates into the output register.
// ----------------------------------------------------------------------------
module slr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [slr_pkg::PITCH_W-1:0]         cfg_wr_data,
  input  logic [2*slr_pkg::SAMPLE_W-1:0]      in_tdata,
  input  slr_pkg::slr_cmd_t                   cmd,
  output slr_pkg::slr_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2*slr_pkg::SAMPLE_W-1:0]      out_tdata,
  output logic                                out_tlast
);

  logic [slr_pkg::PITCH_W-1:0]               pitch_r;
  logic [slr_pkg::PHASE_W-1:0]               phase_r;
  logic signed [slr_pkg::SAMPLE_W-1:0]       prev_l_r, prev_r_r;
  logic signed [slr_pkg::SAMPLE_W-1:0]       cur_l_r, cur_r_r;
  logic [slr_pkg::ACC_W-1:0]                 ph_r;
  logic [slr_pkg::CNT_W-1:0]                 cnt_r;
  logic signed [slr_pkg::PROD_W-1:0]         prod_l_r, prod_r_r;
  logic                                      out_valid_r;
  logic signed [slr_pkg::SAMPLE_W-1:0]       out_l_r, out_r_r;
  logic                                      out_last_r;

  logic [slr_pkg::ACC_W-1:0]                 ph_sum;
  logic                                      last;
  logic signed [slr_pkg::SAMPLE_W-1:0]       res_l, res_r;

  function automatic logic signed [slr_pkg::PROD_W-1:0] lerp_mul(
    input logic signed [slr_pkg::SAMPLE_W-1:0] prev,
    input logic signed [slr_pkg::SAMPLE_W-1:0] cur,
    input logic [slr_pkg::FRAC_BITS-1:0]       frac
  );
    logic signed [slr_pkg::DIFF_W-1:0]          diff;
    logic signed [slr_pkg::FRAC_BITS:0]         sfrac;
    diff  = slr_pkg::DIFF_W'(cur) - slr_pkg::DIFF_W'(prev);
    sfrac = $signed({1'b0, frac});
    return slr_pkg::PROD_W'(diff) * slr_pkg::PROD_W'(sfrac);
  endfunction

  function automatic logic signed [slr_pkg::SAMPLE_W-1:0] lerp_fin(
    input logic signed [slr_pkg::SAMPLE_W-1:0] prev,
    input logic signed [slr_pkg::PROD_W-1:0]   prod
  );
    logic signed [slr_pkg::PROD_W-1:0]          biased;
    logic signed [slr_pkg::QUOT_W-1:0]          quot;
    logic signed [slr_pkg::SUM_W-1:0]           sum;
    // Negative products get a bias so the shift truncates toward zero.
    biased = prod[slr_pkg::PROD_W-1] ? prod + $signed(slr_pkg::ROUND_BIAS) : prod;
    quot   = slr_pkg::QUOT_W'(biased >>> slr_pkg::FRAC_BITS);
    sum    = slr_pkg::SUM_W'(prev) + slr_pkg::SUM_W'(quot);
    if (sum > slr_pkg::SUM_W'(slr_pkg::SAT_MAX)) begin
      return slr_pkg::SAT_MAX;
    end else if (sum < slr_pkg::SUM_W'(slr_pkg::SAT_MIN)) begin
      return slr_pkg::SAT_MIN;
    end
    return slr_pkg::SAMPLE_W'(sum);
  endfunction

  // ph_r is below one step whenever a result is formed, so this cannot wrap.
  assign ph_sum = ph_r + slr_pkg::ACC_W'(pitch_r);
  assign last   = (ph_sum >= slr_pkg::ONE_STEP) || (cnt_r == slr_pkg::CNT_LAST);
  assign res_l  = lerp_fin(prev_l_r, prod_l_r);
  assign res_r  = lerp_fin(prev_r_r, prod_r_r);

  assign sts.phase_whole = slr_pkg::ACC_W'(phase_r) >= slr_pkg::ONE_STEP;
  assign sts.out_busy    = out_valid_r && !out_tready;
  assign sts.last        = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r     <= slr_pkg::PITCH_RESET;
      phase_r     <= '0;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pitch_r <= cfg_wr_data;
      end
      if (cmd.load && cmd.skip) begin
        phase_r  <= slr_pkg::PHASE_W'(slr_pkg::ACC_W'(phase_r) - slr_pkg::ONE_STEP);
        prev_l_r <= in_tdata[slr_pkg::SAMPLE_W-1:0];
        prev_r_r <= in_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W];
      end
      if (cmd.emit && last) begin
        // A run cut off by the result limit restarts from phase zero.
        phase_r  <= (ph_sum >= slr_pkg::ONE_STEP) ?
                    slr_pkg::PHASE_W'(ph_sum - slr_pkg::ONE_STEP) : '0;
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l_r <= in_tdata[slr_pkg::SAMPLE_W-1:0];
      cur_r_r <= in_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W];
      ph_r    <= slr_pkg::ACC_W'(phase_r);
      cnt_r   <= '0;
    end
    if (cmd.mul) begin
      prod_l_r <= lerp_mul(prev_l_r, cur_l_r, ph_r[slr_pkg::FRAC_BITS-1:0]);
      prod_r_r <= lerp_mul(prev_r_r, cur_r_r, ph_r[slr_pkg::FRAC_BITS-1:0]);
    end
    if (cmd.emit) begin
      out_l_r    <= res_l;
      out_r_r    <= res_r;
      out_last_r <= last;
      ph_r       <= ph_sum;
      cnt_r      <= cnt_r + 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r_r, out_l_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_tready))
    else $error("result loaded over an item not yet taken");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output valid raised without an emit");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cnt_r == slr_pkg::CNT_LAST) |=> out_tlast)
    else $error("result limit reached without marking the last item");
`endif

endmodule

/* design/stereo_linear_resampler.sv */
// Flow: a taken input item fills the input registers; for each output item the
//   multiply state registers the products and the finish state, which waits while
//   the output holds an item not taken, loads the output register. No new input item
//   is taken before its last output is loaded; an item making none is done in idle.
// Reset (rst_n low, synchronous) clears phase and previous frame, sets pitch to 1024.
// ----------------------------------------------------------------------------
// stereo_linear_resampler: stereo linear-interpolation rate converter.
// Each 16-bit stereo source item yields zero to 64 interpolated items while
// the 10-bit fractional phase stays below one step.
// ----------------------------------------------------------------------------
module stereo_linear_resampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [slr_pkg::PITCH_W-1:0]     cfg_wr_data,   // pitch
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*slr_pkg::SAMPLE_W-1:0]  in_tdata,      // left_in, right_in
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [2*slr_pkg::SAMPLE_W-1:0]  out_tdata,     // left_out, right_out
  output logic                            out_tlast      // last_out
);

  slr_pkg::slr_cmd_t cmd;
  slr_pkg::slr_sts_t sts;

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the stereo linear resampler
// Drives stereo source items in random bursts under several pitch settings,
// predicts every interpolated output item with a behavioral copy of the
// phase accumulator, and checks the output stream item by item while the
// output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic signed [slr_pkg::SAMPLE_W-1:0] left;
    logic signed [slr_pkg::SAMPLE_W-1:0] right;
    logic                                last;
  } frame_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [slr_pkg::PITCH_W-1:0]      cfg_wr_data = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [2*slr_pkg::SAMPLE_W-1:0]   in_tdata = '0;    // left_in, right_in
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [2*slr_pkg::SAMPLE_W-1:0]   out_tdata;        // left_out, right_out
  logic                             out_tlast;        // last_out

  // Behavioral copy of the block state.
  int acc_phase = 0;
  int hist_left = 0;
  int hist_right = 0;
  int pitch_reg = int'(slr_pkg::PITCH_RESET);

  logic [2*slr_pkg::SAMPLE_W-1:0] pending_frames[$];
  frame_t                         expected_frames[$];
  int                             errors = 0;

  // Sender burst control and receiver stall control.
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int results_seen = 0;
  int cycle_cnt = 0;

  stereo_linear_resampler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [slr_pkg::SAMPLE_W-1:0] lerp_sample(
    int prev, int cur, int ph);
    int val;
    // Integer division in SystemVerilog truncates toward zero.
    val = prev + ((cur - prev) * ph) / (1 << slr_pkg::FRAC_BITS);
    if (val < -32768) val = -32768;
    else if (val > 32767) val = 32767;
    return val[slr_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic interpolate_frame(input logic [2*slr_pkg::SAMPLE_W-1:0] data);
    int     cur_l;
    int     cur_r;
    int     ph;
    int     count;
    frame_t f;
    cur_l = $signed(data[slr_pkg::SAMPLE_W-1:0]);
    cur_r = $signed(data[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W]);
    ph = acc_phase;
    count = 0;
    while (ph < (1 << slr_pkg::FRAC_BITS) && count < slr_pkg::MAX_RESULTS) begin
      f.left = lerp_sample(hist_left, cur_l, ph);
      f.right = lerp_sample(hist_right, cur_r, ph);
      ph += pitch_reg;
      count++;
      f.last = !(ph < (1 << slr_pkg::FRAC_BITS) && count < slr_pkg::MAX_RESULTS);
      expected_frames.push_back(f);
    end
    // When the item limit cuts the loop short, the phase starts over at zero.
    acc_phase = (ph >= (1 << slr_pkg::FRAC_BITS)) ? ph - (1 << slr_pkg::FRAC_BITS) : 0;
    hist_left = cur_l;
    hist_right = cur_r;
  endtask

  function automatic logic [slr_pkg::SAMPLE_W-1:0] pick_sample();
    unique case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2*slr_pkg::SAMPLE_W-1:0] pack_frame(int l, int r);
    return {r[slr_pkg::SAMPLE_W-1:0], l[slr_pkg::SAMPLE_W-1:0]};
  endfunction

  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_pitch(input int value);
    wait_drained();
    // Let any item that makes no output finish before the write.
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[slr_pkg::PITCH_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pitch_reg = value & 32'h7fff;
    @(negedge clk);
  endtask

  // Sender: presents queued items in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) interpolate_frame(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          in_tdata <= pending_frames.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output item and stalls on its own pattern.
  always @(posedge clk) begin
    frame_t want;
    cycle_cnt++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_frames.size() == 0) begin
          $error("output item with nothing expected: left_out=%0d right_out=%0d last_out=%0b",
                 $signed(out_tdata[slr_pkg::SAMPLE_W-1:0]),
                 $signed(out_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W]),
                 out_tlast);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if ($signed(out_tdata[slr_pkg::SAMPLE_W-1:0]) !== want.left) begin
            $error("left_out mismatch: expected %0d, got %0d",
                   want.left, $signed(out_tdata[slr_pkg::SAMPLE_W-1:0]));
            errors++;
          end
          if ($signed(out_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W]) !== want.right) begin
            $error("right_out mismatch: expected %0d, got %0d",
                   want.right, $signed(out_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W]));
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last_out mismatch: expected %0b, got %0b", want.last, out_tlast);
            errors++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && results_seen > 200 && pending_frames.size() > 20) begin
        // One long hold-off while the sender keeps going, so the input backs up.
        hold_done = 1'b1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        unique case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= (cycle_cnt % 4 == 0);
          default: out_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  initial begin
    int pitch_plan[7];
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset pitch: one output item per input, equal to the previous frame.
    pending_frames.push_back(pack_frame(0, 0));
    pending_frames.push_back(pack_frame(32767, -32768));
    pending_frames.push_back(pack_frame(-32768, 32767));
    pending_frames.push_back(pack_frame(-1, 1));
    pending_frames.push_back(pack_frame(32767, 32767));
    pending_frames.push_back(pack_frame(-32768, -32768));

    // Half step: odd negative differences exercise truncation toward zero.
    set_pitch(512);
    pending_frames.push_back(pack_frame(32767, -32768));
    pending_frames.push_back(pack_frame(-32768, 32767));
    pending_frames.push_back(pack_frame(-3, 3));
    pending_frames.push_back(pack_frame(4, -5));
    pending_frames.push_back(pack_frame(21845, -21846));

    // Zero and tiny pitches hit the per-item output limit.
    set_pitch(0);
    pending_frames.push_back(pack_frame(1000, -1000));
    pending_frames.push_back(pack_frame(-32768, 32767));
    set_pitch(1);
    pending_frames.push_back(pack_frame(32767, -32768));
    set_pitch(15);
    pending_frames.push_back(pack_frame(-32768, 32767));
    // Sixty-four steps of 16 land exactly on one whole step.
    set_pitch(16);
    pending_frames.push_back(pack_frame(12345, -12345));

    // Largest pitch: one output item, then a long run of downsampling skips.
    set_pitch(32767);
    pending_frames.push_back(pack_frame(100, 200));
    pending_frames.push_back(pack_frame(-100, -200));
    pending_frames.push_back(pack_frame(32767, -32768));
    pending_frames.push_back(pack_frame(0, 0));
    set_pitch(2048);
    pending_frames.push_back(pack_frame(5000, -5000));
    pending_frames.push_back(pack_frame(-7000, 7000));
    pending_frames.push_back(pack_frame(1, -1));

    pitch_plan[0] = 16384;
    pitch_plan[1] = 16;
    pitch_plan[2] = $urandom_range(17, 16383);
    pitch_plan[3] = $urandom_range(600, 1500);
    pitch_plan[4] = $urandom_range(16, 200);
    pitch_plan[5] = $urandom_range(0, 32767);
    pitch_plan[6] = $urandom_range(16, 16384);
    foreach (pitch_plan[p]) begin
      set_pitch(pitch_plan[p]);
      repeat (42) pending_frames.push_back({pick_sample(), pick_sample()});
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* stereo_linear_resampler.f */
design/slr_pkg.sv
design/slr_ctrl.sv
design/slr_datapath.sv
design/stereo_linear_resampler.sv
sim/testbench.sv
